// File: rtl/core/sshc_pkg.sv
// sshc_pkg: types, constants and helper functions for the source signature
// hash checker; no dependencies, imported by the top level and its checker

package sshc_pkg;

    localparam int HASH_W     = 31;
    localparam int SIG_W      = 32;
    localparam int LEN_W      = 7;
    localparam int OUT_DATA_W = 72;

    localparam logic [LEN_W-1:0] LINE_CAP   = 7'd79;
    localparam logic [LEN_W-1:0] PREFIX_LEN = 7'd14;
    localparam logic [LEN_W-1:0] HEX_END    = 7'd22;
    localparam logic [LEN_W-1:0] SHORT_LEN  = 7'd25;
    localparam logic [LEN_W-1:0] LONG_LEN   = 7'd37;

    localparam logic [HASH_W-1:0] HASH_INIT = 31'd1;

    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_SLASH = 8'h2f;

    // one result item
    typedef struct packed {
        logic              hashes_match;
        logic [SIG_W-1:0]  stored_signature;
        logic              signature_dated;
        logic              signature_found;
        logic [HASH_W-1:0] computed_hash;
    } result_t;

    // one step of the shift-register hash
    function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
                                                    input logic [7:0] b);
        logic [31:0] t;
        logic [31:0] r;
        begin
            t = {h[24:0], 7'b0};
            r = {26'b0, h[30:25]} ^ (t >> 1) ^ (t >> 4) ^ {24'b0, b};
            return r[HASH_W-1:0];
        end
    endfunction

    // expected byte of the fixed prefix "/* Signature: "
    function automatic logic [7:0] prefix_char(input logic [3:0] col);
        logic [7:0] c;
        begin
            case (col)
                4'd0:    c = CH_SLASH;
                4'd1:    c = CH_STAR;
                4'd2:    c = CH_SPACE;
                4'd3:    c = 8'h53;  // S
                4'd4:    c = 8'h69;  // i
                4'd5:    c = 8'h67;  // g
                4'd6:    c = 8'h6e;  // n
                4'd7:    c = 8'h61;  // a
                4'd8:    c = 8'h74;  // t
                4'd9:    c = 8'h75;  // u
                4'd10:   c = 8'h72;  // r
                4'd11:   c = 8'h65;  // e
                4'd12:   c = 8'h3a;  // :
                4'd13:   c = CH_SPACE;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    // {valid, value} of a hex digit character
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        begin
            if (c >= 8'h30 && c <= 8'h39) begin
                d = {1'b1, c[3:0]};
            end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
                d = {1'b1, c[3:0] + 4'd9};
            end else begin
                d = 5'b0;
            end
            return d;
        end
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0d);
    endfunction

endpackage

// File: rtl/core/source_signature_hash_checker.sv
// source_signature_hash_checker: byte-wise file hash with signature line
// detection and an end-of-file report; depends on sshc_pkg
//
// ordering: a byte updates the state at its transfer; the result of an
//   end-of-file item is registered into the output or the skid register
// throughput: one item per cycle while s_tready is high; a two-deep output
//   register holds stalled results, and s_tready drops only when both are full
// reset: aresetn (synchronous, active low) returns the hash and line state
//   to their initial values and empties the output stage

module source_signature_hash_checker
    import sshc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic [0:0]            s_tuser,   // [0] end_of_file
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [30:0] computed_hash, [31] signature_found,
                                             // [32] signature_dated,
                                             // [64:33] stored_signature,
                                             // [65] hashes_match, [71:66] zero
);

    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [HASH_W-1:0] start_reg, start_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              ok_short_reg, ok_short_next;
    logic              ok_long_reg, ok_long_next;
    logic [SIG_W-1:0]  hex_reg, hex_next;
    logic              found_reg, found_next;
    logic              dated_reg, dated_next;
    logic [SIG_W-1:0]  capt_reg, capt_next;

    logic              out_valid_reg, skid_valid_reg;
    result_t           out_reg, skid_reg;
    result_t           result;

    logic              s_xfer, m_xfer, push;
    logic [7:0]        c;
    logic [HASH_W-1:0] stepped;
    logic [4:0]        hexd;

    assign s_tready = !skid_valid_reg;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_xfer   = out_valid_reg && m_tready;
    assign push     = s_xfer && s_tuser[0];
    assign c        = s_tdata;
    assign stepped  = hash_step(hash_reg, c);
    assign hexd     = hex_digit(c);

    // report of the current file
    always_comb begin
        result.computed_hash    = hash_reg;
        result.signature_found  = found_reg;
        result.signature_dated  = dated_reg;
        result.stored_signature = capt_reg;
        result.hashes_match     = found_reg && (capt_reg == {1'b0, hash_reg});
    end

    // per-byte hash, column template check and signature capture
    always_comb begin
        hash_next     = hash_reg;
        start_next    = start_reg;
        len_next      = len_reg;
        ok_short_next = ok_short_reg;
        ok_long_next  = ok_long_reg;
        hex_next      = hex_reg;
        found_next    = found_reg;
        dated_next    = dated_reg;
        capt_next     = capt_reg;
        if (s_xfer) begin
            if (s_tuser[0]) begin
                hash_next     = HASH_INIT;
                start_next    = HASH_INIT;
                len_next      = '0;
                ok_short_next = 1'b1;
                ok_long_next  = 1'b1;
                hex_next      = '0;
                found_next    = 1'b0;
                dated_next    = 1'b0;
                capt_next     = '0;
            end else if (c == CH_NL) begin
                hash_next = stepped;
                if (!found_reg && len_reg == LONG_LEN && ok_long_reg) begin
                    found_next = 1'b1;
                    dated_next = 1'b1;
                    capt_next  = hex_reg;
                    hash_next  = start_reg;
                end else if (!found_reg && len_reg == SHORT_LEN && ok_short_reg) begin
                    found_next = 1'b1;
                    dated_next = 1'b0;
                    capt_next  = hex_reg;
                    hash_next  = start_reg;
                end
                start_next    = hash_next;
                len_next      = '0;
                ok_short_next = 1'b1;
                ok_long_next  = 1'b1;
                hex_next      = '0;
            end else begin
                hash_next = stepped;
                if (len_reg < LINE_CAP) begin
                    len_next = len_reg + 7'd1;
                    if (len_reg < PREFIX_LEN) begin
                        // fixed prefix
                        if (c != prefix_char(len_reg[3:0])) begin
                            ok_short_next = 1'b0;
                            ok_long_next  = 1'b0;
                        end
                    end else if (len_reg < HEX_END) begin
                        // eight hex digits
                        if (!hexd[4]) begin
                            ok_short_next = 1'b0;
                            ok_long_next  = 1'b0;
                        end else begin
                            hex_next = {hex_reg[SIG_W-5:0], hexd[3:0]};
                        end
                    end else begin
                        // undated tail " */"
                        case (len_reg)
                            7'd22:   ok_short_next = ok_short_reg && (c == CH_SPACE);
                            7'd23:   ok_short_next = ok_short_reg && (c == CH_STAR);
                            7'd24:   ok_short_next = ok_short_reg && (c == CH_SLASH);
                            default: ok_short_next = 1'b0;
                        endcase
                        // dated tail " DDDDDDDDDDD */"
                        if (len_reg == 7'd22 || len_reg == 7'd34) begin
                            ok_long_next = ok_long_reg && (c == CH_SPACE);
                        end else if (len_reg <= 7'd33) begin
                            ok_long_next = ok_long_reg && !is_space(c);
                        end else if (len_reg == 7'd35) begin
                            ok_long_next = ok_long_reg && (c == CH_STAR);
                        end else if (len_reg == 7'd36) begin
                            ok_long_next = ok_long_reg && (c == CH_SLASH);
                        end else begin
                            ok_long_next = 1'b0;
                        end
                    end
                end
            end
        end
    end

    // hash and line state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg     <= HASH_INIT;
            start_reg    <= HASH_INIT;
            len_reg      <= '0;
            ok_short_reg <= 1'b1;
            ok_long_reg  <= 1'b1;
            hex_reg      <= '0;
            found_reg    <= 1'b0;
            dated_reg    <= 1'b0;
            capt_reg     <= '0;
        end else begin
            hash_reg     <= hash_next;
            start_reg    <= start_next;
            len_reg      <= len_next;
            ok_short_reg <= ok_short_next;
            ok_long_reg  <= ok_long_next;
            hex_reg      <= hex_next;
            found_reg    <= found_next;
            dated_reg    <= dated_next;
            capt_reg     <= capt_next;
        end
    end

    // output register and skid stage, valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_xfer) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (out_valid_reg && !m_tready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (m_xfer) begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register and skid stage, payload
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_xfer) begin
                out_reg <= skid_reg;
            end
        end else if (push) begin
            if (out_valid_reg && !m_tready) begin
                skid_reg <= result;
            end else begin
                out_reg <= result;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg};

endmodule

// File: rtl/core/sshc_checker.sv
// sshc_checker: port-level assertions for source_signature_hash_checker,
// bound to the top level below; depends on sshc_pkg

module sshc_checker
    import sshc_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // input stalls only while a result is waiting
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // no signature means empty fields and no match
    a_none: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[31] |-> m_tdata[64:33] == '0 && !m_tdata[32] && !m_tdata[65])
        else $error("fields set without a signature");

    // a match means the stored value equals the hash
    a_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[65] == (m_tdata[31] && m_tdata[64:33] == {1'b0, m_tdata[30:0]}))
        else $error("match flag inconsistent");

endmodule

bind source_signature_hash_checker sshc_checker u_sshc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
